FILE: hw/rtl/wcp_pkg.sv
// Package for the wave container parser: parse phases, result kinds,
// error codes, chunk tags and size constants. No dependencies.
`timescale 1ns / 1ps

package wcp_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HEADER,
        PH_FMT,
        PH_SKIP,
        PH_PAYLOAD
    } phase_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_NO_RIFF   = 3'd2;
    localparam logic [2:0] ERR_NO_WAVE   = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd4;
    localparam logic [2:0] ERR_NO_DATA   = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;
    localparam logic [2:0] ERR_SHORT_FMT = 3'd7;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [63:0] MIN_LENGTH   = 64'd44;
    localparam logic [63:0] FIRST_CHUNK  = 64'd12;
    localparam logic [63:0] FMT_BYTES    = 64'd16;
    localparam logic [63:0] HEADER_BYTES = 64'd8;

    localparam logic [0:0] REG_STREAM_LENGTH = 1'b0;

endpackage

FILE: hw/rtl/wave_container_parser_core.sv
// Wave container parser top level: byte-serial RIFF/WAVE header walker.
// Depends on wcp_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (byte_valid/byte_ready) carries one file byte per transfer;
//   start_of_stream on a byte restarts parsing with that byte as byte 0.
//   Output channel (result_valid/result_ready) carries data headers, payload
//   bytes and parse failures; zero or one result per input byte.
//   stream_length is written over the APB port (address 0) while idle.
// Timing:
//   Each byte is parsed in the cycle it is transferred; its result sits in
//   the output register from the next cycle. Throughput is one byte per
//   cycle while the receiver takes results, set by the single output register.
//   byte_ready = !result_valid || result_ready, so a stalled receiver holds
//   the pending result and blocks further input until it is taken.
// Reset:
//   rst_n clears the parse state, stream_length and the output valid.
//   After a failure, a zero-length data header or the last payload byte, bytes
//   are dropped until the next start_of_stream.
module wave_container_parser_core
    import wcp_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,
    input  logic        start_of_stream,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic [1:0]  format_code,
    output logic        format_seen,
    output logic [31:0] sample_rate,
    output logic [31:0] payload_length,
    output logic [2:0]  error_code
);

    logic [31:0]            stream_length_reg;
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    phase_t                 phase_reg, phase_next;
    logic [31:0]            tag_reg, tag_next;
    logic [31:0]            size_reg, size_next;
    logic [32:0]            left_reg, left_next;
    logic [63:0]            fmt_reg, fmt_next;
    logic                   fvalid_reg, fvalid_next;
    logic                   finished_reg, finished_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  pbyte_reg;
    logic        plast_reg;
    logic [1:0]  fcode_reg;
    logic        fseen_reg;
    logic [31:0] rate_reg;
    logic [31:0] plen_reg;
    logic [2:0]  err_reg;

    logic        fire_next;
    logic [1:0]  kind_next;
    logic [7:0]  pbyte_next;
    logic        plast_next;
    logic [1:0]  fcode_next;
    logic        fseen_next;
    logic [31:0] rate_next;
    logic [31:0] plen_next;
    logic [2:0]  err_next;

    // effective state after an optional restart
    logic                   take;
    logic [COUNT_WIDTH-1:0] eff_pos;
    phase_t                 eff_phase;
    logic [31:0]            eff_tag;
    logic [31:0]            eff_size;
    logic [32:0]            eff_left;
    logic [63:0]            eff_fmt;
    logic                   eff_fvalid;
    logic                   eff_done;

    logic [COUNT_WIDTH-1:0] pos_inc;
    logic [63:0]            next64;
    logic [63:0]            len64;
    logic [31:0]            tag_shift;
    logic [2:0]             hdr_idx;
    logic [3:0]             fmt_idx;
    logic [31:0]            size_new;
    logic [63:0]            hdr_adv;
    logic [63:0]            fmt_adv;
    logic [63:0]            adv_n;
    logic                   adv_fail;
    logic                   riff_len_fail;
    logic                   riff_tag_fail;
    logic                   wave_tag_fail;
    logic                   riff_adv_fail;
    logic                   fmt_short;
    logic                   data_trunc;
    logic                   pcm_fail;
    logic [32:0]            left_dec;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_STREAM_LENGTH) ? stream_length_reg : 32'd0;

    assign byte_ready = !out_valid_reg || result_ready;
    assign take       = byte_valid && byte_ready;

    assign eff_pos    = start_of_stream ? '0 : pos_reg;
    assign eff_phase  = start_of_stream ? PH_RIFF : phase_reg;
    assign eff_tag    = start_of_stream ? 32'd0 : tag_reg;
    assign eff_size   = start_of_stream ? 32'd0 : size_reg;
    assign eff_left   = start_of_stream ? 33'd0 : left_reg;
    assign eff_fmt    = start_of_stream ? 64'd0 : fmt_reg;
    assign eff_fvalid = start_of_stream ? 1'b0 : fvalid_reg;
    assign eff_done   = start_of_stream ? 1'b0 : finished_reg;

    assign pos_inc   = eff_pos + COUNT_WIDTH'(1);
    assign next64    = 64'(pos_inc);
    assign len64     = 64'(stream_length_reg);
    assign tag_shift = {eff_tag[23:0], in_byte};
    assign hdr_idx   = 3'(3'd0 - eff_left[2:0]);
    assign fmt_idx   = 4'(4'd0 - eff_left[3:0]);
    assign left_dec  = eff_left - 33'd1;

    always_comb
    begin
        size_new = eff_size;
        case (hdr_idx)
            3'd4:    size_new = {24'd0, in_byte};
            3'd5:    size_new[15:8]  = in_byte;
            3'd6:    size_new[23:16] = in_byte;
            3'd7:    size_new[31:24] = in_byte;
            default: size_new = eff_size;
        endcase
    end

    assign hdr_adv  = 64'(size_new) + 64'(size_new[0]);
    assign fmt_adv  = 64'(eff_size) - FMT_BYTES + 64'(eff_size[0]);
    assign adv_n    = (eff_phase == PH_FMT) ? fmt_adv : hdr_adv;
    assign adv_fail = (next64 + adv_n + HEADER_BYTES) >= len64;

    assign riff_len_fail = (eff_pos == '0) && (len64 < MIN_LENGTH);
    assign riff_tag_fail = (eff_pos == COUNT_WIDTH'(3)) && (tag_shift != TAG_RIFF);
    assign wave_tag_fail = (eff_pos == COUNT_WIDTH'(11)) && (tag_shift != TAG_WAVE);
    assign riff_adv_fail = (FIRST_CHUNK + HEADER_BYTES) >= len64;
    assign fmt_short     = (size_new < 32'(FMT_BYTES)) || ((next64 + FMT_BYTES) > len64);
    assign data_trunc    = (next64 + 64'(size_new)) > len64;
    assign pcm_fail      = (eff_tag | {16'd0, in_byte, 8'd0}) != 32'd1;

    // next parse state
    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        left_next     = left_reg;
        fmt_next      = fmt_reg;
        fvalid_next   = fvalid_reg;
        finished_next = finished_reg;
        if (take)
        begin
            pos_next      = eff_pos;
            phase_next    = eff_phase;
            tag_next      = eff_tag;
            size_next     = eff_size;
            left_next     = eff_left;
            fmt_next      = eff_fmt;
            fvalid_next   = eff_fvalid;
            finished_next = eff_done;
            if (!eff_done)
            begin
                pos_next = pos_inc;
                case (eff_phase)
                    PH_RIFF:
                    begin
                        if (riff_len_fail)
                        begin
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            tag_next = tag_shift;
                            if (riff_tag_fail || wave_tag_fail)
                            begin
                                finished_next = 1'b1;
                            end
                            else if (eff_pos == COUNT_WIDTH'(11))
                            begin
                                tag_next = 32'd0;
                                if (riff_adv_fail)
                                begin
                                    finished_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_HEADER;
                                    left_next  = 33'(HEADER_BYTES);
                                end
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        if (hdr_idx < 3'd4)
                        begin
                            tag_next = tag_shift;
                        end
                        else
                        begin
                            size_next = size_new;
                        end
                        left_next = {30'd0, 3'(eff_left[2:0] - 3'd1)};
                        if (hdr_idx == 3'd7)
                        begin
                            if (eff_tag == TAG_FMT)
                            begin
                                if (fmt_short)
                                begin
                                    finished_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_FMT;
                                    left_next  = 33'(FMT_BYTES);
                                end
                            end
                            else if (eff_tag == TAG_DATA)
                            begin
                                if (data_trunc || size_new == 32'd0)
                                begin
                                    finished_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                    left_next  = 33'(size_new);
                                end
                            end
                            else if (adv_fail)
                            begin
                                finished_next = 1'b1;
                            end
                            else if (adv_n == 64'd0)
                            begin
                                phase_next = PH_HEADER;
                                left_next  = 33'(HEADER_BYTES);
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                                left_next  = adv_n[32:0];
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        left_next = {28'd0, 5'(eff_left[4:0] - 5'd1)};
                        case (fmt_idx)
                            4'd0:    tag_next = {24'd0, in_byte};
                            4'd1:    finished_next = pcm_fail;
                            4'd2:    fmt_next[39:32] = in_byte;
                            4'd3:    fmt_next[47:40] = in_byte;
                            4'd4:    fmt_next[7:0]   = in_byte;
                            4'd5:    fmt_next[15:8]  = in_byte;
                            4'd6:    fmt_next[23:16] = in_byte;
                            4'd7:    fmt_next[31:24] = in_byte;
                            4'd14:   fmt_next[55:48] = in_byte;
                            4'd15:   fmt_next[63:56] = in_byte;
                            default: fmt_next = eff_fmt;
                        endcase
                        if (fmt_idx == 4'd15)
                        begin
                            fvalid_next = 1'b1;
                            if (adv_fail)
                            begin
                                finished_next = 1'b1;
                            end
                            else if (adv_n == 64'd0)
                            begin
                                phase_next = PH_HEADER;
                                left_next  = 33'(HEADER_BYTES);
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                                left_next  = adv_n[32:0];
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        left_next = left_dec;
                        if (left_dec == 33'd0)
                        begin
                            phase_next = PH_HEADER;
                            left_next  = 33'(HEADER_BYTES);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == 33'd0)
                        begin
                            finished_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        finished_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // result of the current byte
    always_comb
    begin
        fire_next  = 1'b0;
        kind_next  = KIND_HEADER;
        pbyte_next = 8'd0;
        plast_next = 1'b0;
        fcode_next = 2'd0;
        fseen_next = 1'b0;
        rate_next  = 32'd0;
        plen_next  = 32'd0;
        err_next   = ERR_OK;
        if (!eff_done)
        begin
            case (eff_phase)
                PH_RIFF:
                begin
                    if (riff_len_fail)
                    begin
                        err_next = ERR_SHORT;
                    end
                    else if (riff_tag_fail)
                    begin
                        err_next = ERR_NO_RIFF;
                    end
                    else if (wave_tag_fail)
                    begin
                        err_next = ERR_NO_WAVE;
                    end
                    else if (eff_pos == COUNT_WIDTH'(11) && riff_adv_fail)
                    begin
                        err_next = ERR_NO_DATA;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_idx == 3'd7)
                    begin
                        if (eff_tag == TAG_FMT)
                        begin
                            if (fmt_short)
                            begin
                                err_next = ERR_SHORT_FMT;
                            end
                        end
                        else if (eff_tag == TAG_DATA)
                        begin
                            if (data_trunc)
                            begin
                                err_next = ERR_TRUNCATED;
                            end
                            else
                            begin
                                fire_next = 1'b1;
                                plen_next = size_new;
                                if (eff_fvalid)
                                begin
                                    fcode_next = {eff_fmt[47:32] != 16'd1,
                                                  eff_fmt[63:48] != 16'd8};
                                    fseen_next = 1'b1;
                                    rate_next  = eff_fmt[31:0];
                                end
                            end
                        end
                        else if (adv_fail)
                        begin
                            err_next = ERR_NO_DATA;
                        end
                    end
                end
                PH_FMT:
                begin
                    if (fmt_idx == 4'd1 && pcm_fail)
                    begin
                        err_next = ERR_NOT_PCM;
                    end
                    else if (fmt_idx == 4'd15 && adv_fail)
                    begin
                        err_next = ERR_NO_DATA;
                    end
                end
                PH_PAYLOAD:
                begin
                    fire_next  = 1'b1;
                    kind_next  = KIND_PAYLOAD;
                    pbyte_next = in_byte;
                    plast_next = (left_dec == 33'd0);
                end
                default:
                begin
                    fire_next = 1'b0;
                end
            endcase
            if (err_next != ERR_OK)
            begin
                fire_next = 1'b1;
                kind_next = KIND_FAIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= 32'd0;
            pos_reg           <= '0;
            phase_reg         <= PH_RIFF;
            tag_reg           <= 32'd0;
            size_reg          <= 32'd0;
            left_reg          <= 33'd0;
            fmt_reg           <= 64'd0;
            fvalid_reg        <= 1'b0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2:2] == REG_STREAM_LENGTH)
            begin
                stream_length_reg <= pwdata;
            end
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            left_reg     <= left_next;
            fmt_reg      <= fmt_next;
            fvalid_reg   <= fvalid_next;
            finished_reg <= finished_next;
            if (take && fire_next)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && fire_next)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            plast_reg <= plast_next;
            fcode_reg <= fcode_next;
            fseen_reg <= fseen_next;
            rate_reg  <= rate_next;
            plen_reg  <= plen_next;
            err_reg   <= err_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign result_kind    = kind_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_last   = plast_reg;
    assign format_code    = fcode_reg;
    assign format_seen    = fseen_reg;
    assign sample_rate    = rate_reg;
    assign payload_length = plen_reg;
    assign error_code     = err_reg;

endmodule

FILE: hw/rtl/wcp_checker.sv
// Port-level checks for the wave container parser, bound to the top level.
// Depends on wcp_pkg and wave_container_parser_core.
`timescale 1ns / 1ps

module wcp_checker
    import wcp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  result_kind,
    input logic [7:0]  payload_byte,
    input logic        payload_last,
    input logic [2:0]  error_code
);

    // input is taken exactly when the output register can move
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ready == (!result_valid || result_ready))
        else $error("byte_ready does not track output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_kind) && $stable(payload_byte)
            && $stable(error_code))
        else $error("pending result changed under stall");

    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && payload_last |-> result_kind == KIND_PAYLOAD)
        else $error("payload_last on a non-payload result");

    a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_FAIL |-> error_code != ERR_OK)
        else $error("failure without error code");

    a_code_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != KIND_FAIL |-> error_code == ERR_OK)
        else $error("error code on a non-failure result");

endmodule

bind wave_container_parser_core wcp_checker u_wcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .error_code   (error_code)
);

FILE: bench/wave_container_parser_core_tb.sv
// Testbench for wave_container_parser_core: streams directed and random RIFF/WAVE files
// through the byte channel, predicts every header, payload and failure result in-bench,
// and checks them in order. Depends on wcp_pkg and the core RTL.
`timescale 1ns / 1ps

module wave_container_parser_core_tb;
    import wcp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 800;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 150;
    localparam logic [2:0] STREAM_LENGTH_ADDR = 3'(4 * REG_STREAM_LENGTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pbyte;
        logic        plast;
        logic [1:0]  fcode;
        logic        fseen;
        logic [31:0] rate;
        logic [31:0] plen;
        logic [2:0]  err;
    } wave_result_t;

    typedef struct {
        logic [7:0]  value;
        logic        mark;
        int unsigned gap;
    } file_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  in_byte = '0;
    logic        start_of_stream = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  format_code;
    logic        format_seen;
    logic [31:0] sample_rate;
    logic [31:0] payload_length;
    logic [2:0]  error_code;

    wave_container_parser_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .in_byte        (in_byte),
        .start_of_stream(start_of_stream),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .payload_last   (payload_last),
        .format_code    (format_code),
        .format_seen    (format_seen),
        .sample_rate    (sample_rate),
        .payload_length (payload_length),
        .error_code     (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // parser state mirror
    logic [31:0] cfg_stream_len = '0;
    logic [31:0] pos_q = '0;
    phase_t      phase_q = PH_RIFF;
    logic [31:0] tag_q = '0;
    logic [31:0] size_q = '0;
    logic [32:0] left_q = '0;
    logic [63:0] fmt_q = '0;
    logic        fmt_ok_q = 1'b0;
    logic        done_q = 1'b0;

    wave_result_t parsed_results[$];
    file_byte_t   file_bytes[$];
    logic [7:0]   img[$];

    file_byte_t   next_byte;
    bit           tx_armed = 1'b0;
    int unsigned  tx_wait = 0;
    bit           tx_no_gap = 1'b0;
    bit           rx_no_stall = 1'b0;
    int unsigned  rx_wait = 0;
    int unsigned  rx_hold = 0;
    int unsigned  results_taken = 0;
    int unsigned  random_bytes = 0;
    int unsigned  fail_count = 0;
    int unsigned  quiet_cycles = 0;
    wave_result_t seen_result;
    wave_result_t want_result;

    function automatic string show_result(wave_result_t r);
        return $sformatf({"kind=%0d byte=%02h last=%0d fmt=%0d seen=%0d",
                          " rate=%08h len=%08h err=%0d"},
                         r.kind, r.pbyte, r.plast, r.fcode, r.fseen, r.rate, r.plen, r.err);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void expect_result(wave_result_t r);
        parsed_results.insert(parsed_results.size(), r);
    endfunction

    function automatic void restart_parse();
        pos_q = '0;
        phase_q = PH_RIFF;
        tag_q = '0;
        size_q = '0;
        left_q = '0;
        fmt_q = '0;
        fmt_ok_q = 1'b0;
        done_q = 1'b0;
    endfunction

    function automatic void push_failure(logic [2:0] code);
        wave_result_t r;
        r = '0;
        r.kind = KIND_FAIL;
        r.err = code;
        done_q = 1'b1;
        expect_result(r);
    endfunction

    // chunk ends after n more bytes from position from; next header must still fit
    function automatic void skip_to_next_chunk(logic [63:0] from, logic [63:0] n);
        if (from + n + HEADER_BYTES >= {32'd0, cfg_stream_len})
            push_failure(ERR_NO_DATA);
        else if (n == 0)
        begin
            phase_q = PH_HEADER;
            left_q = 33'd8;
        end
        else
        begin
            phase_q = PH_SKIP;
            left_q = n[32:0];
        end
    endfunction

    function automatic void walk_wave_byte(logic [7:0] b, logic mark);
        logic [31:0]  here;
        logic [63:0]  nxt;
        logic [63:0]  len64;
        logic [2:0]   hslot;
        logic [3:0]   fslot;
        wave_result_t r;
        if (mark)
            restart_parse();
        if (done_q)
            return;
        here = pos_q;
        pos_q = pos_q + 32'd1;
        nxt = {32'd0, pos_q};
        len64 = {32'd0, cfg_stream_len};
        case (phase_q)
            PH_RIFF:
            begin
                if (here == 0 && len64 < MIN_LENGTH)
                begin
                    push_failure(ERR_SHORT);
                    return;
                end
                tag_q = {tag_q[23:0], b};
                if (here == 3 && tag_q != TAG_RIFF)
                    push_failure(ERR_NO_RIFF);
                else if (here == 11)
                begin
                    if (tag_q != TAG_WAVE)
                        push_failure(ERR_NO_WAVE);
                    else
                    begin
                        tag_q = '0;
                        skip_to_next_chunk(FIRST_CHUNK, 64'd0);
                    end
                end
            end
            PH_HEADER:
            begin
                hslot = 3'(64'd8 - 64'(left_q));
                if (hslot < 4)
                    tag_q = {tag_q[23:0], b};
                else
                begin
                    if (hslot == 4)
                        size_q = '0;
                    size_q = size_q | (32'(b) << (8 * (int'(hslot) - 4)));
                end
                left_q = (left_q - 33'd1) & 33'd7;
                if (hslot != 7)
                    return;
                if (tag_q == TAG_FMT)
                begin
                    if (64'(size_q) < FMT_BYTES || nxt + FMT_BYTES > len64)
                        push_failure(ERR_SHORT_FMT);
                    else
                    begin
                        phase_q = PH_FMT;
                        left_q = 33'(FMT_BYTES);
                    end
                end
                else if (tag_q == TAG_DATA)
                begin
                    if (nxt + {32'd0, size_q} > len64)
                        push_failure(ERR_TRUNCATED);
                    else
                    begin
                        r = '0;
                        r.kind = KIND_HEADER;
                        if (fmt_ok_q)
                        begin
                            r.fcode = {fmt_q[47:32] != 16'd1, fmt_q[63:48] != 16'd8};
                            r.fseen = 1'b1;
                            r.rate = fmt_q[31:0];
                        end
                        r.plen = size_q;
                        expect_result(r);
                        if (size_q == 0)
                            done_q = 1'b1;
                        else
                        begin
                            phase_q = PH_PAYLOAD;
                            left_q = {1'b0, size_q};
                        end
                    end
                end
                else
                    skip_to_next_chunk(nxt, {32'd0, size_q} + 64'(size_q[0]));
            end
            PH_FMT:
            begin
                fslot = 4'(64'd16 - 64'(left_q));
                left_q = (left_q - 33'd1) & 33'd31;
                if (fslot == 0)
                    tag_q = {24'd0, b};
                else if (fslot == 1)
                begin
                    if ((tag_q | {16'd0, b, 8'd0}) != 32'd1)
                    begin
                        push_failure(ERR_NOT_PCM);
                        return;
                    end
                end
                else if (fslot == 2 || fslot == 3)
                    fmt_q[32 + 8 * (int'(fslot) - 2) +: 8] = b;
                else if (fslot >= 4 && fslot <= 7)
                    fmt_q[8 * (int'(fslot) - 4) +: 8] = b;
                else if (fslot == 14 || fslot == 15)
                    fmt_q[48 + 8 * (int'(fslot) - 14) +: 8] = b;
                if (fslot != 15)
                    return;
                fmt_ok_q = 1'b1;
                skip_to_next_chunk(nxt, {32'd0, size_q} - FMT_BYTES + 64'(size_q[0]));
            end
            PH_SKIP:
            begin
                left_q = left_q - 33'd1;
                if (left_q == 0)
                begin
                    phase_q = PH_HEADER;
                    left_q = 33'd8;
                end
            end
            PH_PAYLOAD:
            begin
                left_q = left_q - 33'd1;
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.pbyte = b;
                if (left_q == 0)
                begin
                    r.plast = 1'b1;
                    done_q = 1'b1;
                end
                expect_result(r);
            end
            default:
                done_q = 1'b1;
        endcase
    endfunction

    // file image builders
    function automatic void put8(logic [7:0] b);
        img.insert(img.size(), b);
    endfunction

    function automatic void put_tag(logic [31:0] t);
        put8(t[31:24]);
        put8(t[23:16]);
        put8(t[15:8]);
        put8(t[7:0]);
    endfunction

    function automatic void put_le16(logic [15:0] v);
        put8(v[7:0]);
        put8(v[15:8]);
    endfunction

    function automatic void put_le32(logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endfunction

    function automatic void put_riff(logic [31:0] len);
        put_tag(TAG_RIFF);
        put_le32(len - 32'd8);
        put_tag(TAG_WAVE);
    endfunction

    function automatic void put_chunk(logic [31:0] tag, logic [31:0] size, int unsigned body);
        put_tag(tag);
        put_le32(size);
        repeat (body) put8(8'($urandom));
    endfunction

    function automatic void put_fmt(logic [31:0] size, logic [15:0] ftag, logic [15:0] chans,
                                    logic [31:0] rate, logic [15:0] bits);
        put_tag(TAG_FMT);
        put_le32(size);
        if (size < 16)
            repeat (size + size[0]) put8(8'($urandom));
        else
        begin
            put_le16(ftag);
            put_le16(chans);
            put_le32(rate);
            put_le32($urandom);
            put_le16(16'($urandom));
            put_le16(bits);
            repeat (size - 16 + size[0]) put8(8'($urandom));
        end
    endfunction

    function automatic void send_image(bit mark);
        file_byte_t fb;
        foreach (img[i])
        begin
            fb.value = img[i];
            fb.mark = mark && (i == 0);
            fb.gap = tx_no_gap ? 0 : $urandom_range(0, 4);
            file_bytes.insert(file_bytes.size(), fb);
        end
        if (mark)
            random_bytes += img.size();
        img.delete();
    endfunction

    function automatic void random_wave_file(logic [31:0] slen);
        logic [63:0] used;
        logic [15:0] chans;
        logic [15:0] bits;
        int unsigned sz;
        int unsigned dsz;
        int unsigned k;
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 20)) put8(8'($urandom));
            send_image(1'b1);
            return;
        end
        put_riff(slen);
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 19) == 0)
                    sz = $urandom_range(0, 15);
                else
                    sz = ($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 5) : 16;
                case ($urandom_range(0, 2))
                    0: chans = 16'd1;
                    1: chans = 16'd2;
                    default: chans = 16'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0: bits = 16'd8;
                    1: bits = 16'd16;
                    default: bits = 16'($urandom);
                endcase
                put_fmt(sz, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1, chans,
                        $urandom, bits);
            end
            else
            begin
                sz = $urandom_range(0, 9);
                put_chunk($urandom, sz, sz + sz % 2);
            end
        end
        used = 64'(img.size()) + 64'd8;
        if ({32'd0, slen} > used && {32'd0, slen} - used <= 64'd240)
            dsz = 32'({32'd0, slen} - used);
        else
            dsz = $urandom_range(0, 40);
        if ($urandom_range(0, 15) == 0)
            dsz = dsz + $urandom_range(1, 4);
        put_chunk(TAG_DATA, dsz, dsz);
        case ($urandom_range(0, 9))
            0:
            begin
                k = $urandom_range(0, (img.size() < 48) ? img.size() - 1 : 47);
                img[k] = img[k] ^ 8'($urandom_range(1, 255));
            end
            1:
            begin
                k = $urandom_range(1, img.size());
                while (img.size() > k)
                    void'(img.pop_back());
            end
            default: ;
        endcase
        send_image(1'b1);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) put8(8'($urandom));
            send_image(1'b0);
        end
    endfunction

    task automatic pick_pacing();
        tx_no_gap = ($urandom_range(0, 3) == 0);
        rx_no_stall = ($urandom_range(0, 3) == 0);
    endtask

    task automatic program_stream_length(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STREAM_LENGTH_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_stream_len = value;
    endtask

    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (file_bytes.size() != 0 || tx_armed || byte_valid || parsed_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic directed_files();
        pick_pacing();
        program_stream_length(32'd0);
        put8(8'($urandom));
        send_image(1'b0);           // first byte after reset, no start mark
        put8(8'hFF);
        send_image(1'b1);
        put8(8'h00);
        send_image(1'b0);           // dropped after failure
        drain_and_settle();

        program_stream_length(32'd43);
        put8(8'h52);
        send_image(1'b1);
        drain_and_settle();

        pick_pacing();
        program_stream_length(32'd44);
        put_riff(32'd44);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 16'd8);
        put_chunk(TAG_DATA, 32'd0, 0);
        send_image(1'b1);           // no room for data header
        drain_and_settle();

        pick_pacing();
        program_stream_length(32'd60);
        put_riff(32'd60);
        img[1] = img[1] ^ 8'h20;
        send_image(1'b1);
        put_riff(32'd60);
        img[11] = img[11] ^ 8'h01;
        send_image(1'b1);
        put_riff(32'd60);
        put_fmt(32'd16, 16'd3, 16'd2, 32'd44100, 16'd16);
        send_image(1'b1);
        put_riff(32'd60);
        put_fmt(32'd14, 16'd1, 16'd1, 32'd8000, 16'd8);
        send_image(1'b1);
        put_riff(32'd60);
        put_chunk(TAG_DATA, 32'd200, 4);
        send_image(1'b1);
        put_riff(32'd60);
        put_fmt(32'd16, 16'd1, 16'd2, 32'd48000, 16'd16);
        put_chunk(TAG_DATA, 32'd16, 16);
        put8(8'hA5);
        send_image(1'b1);
        put_riff(32'd60);
        put_chunk(32'h4C49_5354, 32'd3, 4);
        put_chunk(TAG_DATA, 32'd28, 28);
        send_image(1'b1);
        put_riff(32'd60);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd22050, 16'd16);
        put_chunk(TAG_DATA, 32'd0, 0);
        put8(8'h00);
        send_image(1'b1);
        put_riff(32'd60);
        put_tag(TAG_FMT);
        send_image(1'b1);           // cut short by the next start mark
        drain_and_settle();

        pick_pacing();
        program_stream_length(32'd100);
        put_riff(32'd100);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd11025, 16'd8);
        put_fmt(32'd17, 16'd1, 16'd2, 32'd96000, 16'd8);
        put_chunk(TAG_DATA, 32'd30, 30);
        send_image(1'b1);
        drain_and_settle();

        pick_pacing();
        program_stream_length(32'hFFFF_FFFF);
        put_riff(32'hFFFF_FFFF);
        put_chunk(32'h4A55_4E4B, 32'hFFFF_FFFF, 0);
        send_image(1'b1);
        put_riff(32'hFFFF_FFFF);
        put_chunk(TAG_DATA, 32'hFFFF_FFFF, 2);
        send_image(1'b1);
        put_riff(32'hFFFF_FFFF);
        put_fmt(32'd16, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_chunk(TAG_DATA, 32'd3, 3);
        send_image(1'b1);
        drain_and_settle();
    endtask

    initial
    begin
        logic [31:0] slen;
        int unsigned phase_goal;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        directed_files();
        while (random_bytes < RANDOM_BYTES)
        begin
            pick_pacing();
            case ($urandom_range(0, 9))
                0: slen = 32'd44 + $urandom_range(0, 6);
                1: slen = $urandom;
                2: slen = 32'hFFFF_FFFF - $urandom_range(0, 255);
                default: slen = $urandom_range(60, 220);
            endcase
            program_stream_length(slen);
            phase_goal = random_bytes + 120;
            while (random_bytes < phase_goal)
                random_wave_file(slen);
            drain_and_settle();
        end
        if (fail_count == 0 && parsed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                walk_wave_byte(in_byte, start_of_stream);
            if (!byte_valid || byte_ready)
            begin
                if (!tx_armed && file_bytes.size() != 0)
                begin
                    next_byte = file_bytes.pop_front();
                    tx_wait = next_byte.gap;
                    tx_armed = 1'b1;
                end
                if (tx_armed && tx_wait == 0)
                begin
                    byte_valid <= 1'b1;
                    in_byte <= next_byte.value;
                    start_of_stream <= next_byte.mark;
                    tx_armed = 1'b0;
                end
                else
                begin
                    if (tx_armed)
                        tx_wait--;
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver pacing
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                seen_result.kind = result_kind;
                seen_result.pbyte = payload_byte;
                seen_result.plast = payload_last;
                seen_result.fcode = format_code;
                seen_result.fseen = format_seen;
                seen_result.rate = sample_rate;
                seen_result.plen = payload_length;
                seen_result.err = error_code;
                if (parsed_results.size() == 0)
                    note_failure({"unexpected result: ", show_result(seen_result)});
                else
                begin
                    want_result = parsed_results.pop_front();
                    if (seen_result !== want_result)
                        note_failure({"mismatch: expected ", show_result(want_result),
                                      " got ", show_result(seen_result)});
                end
                results_taken++;
                rx_wait = rx_no_stall ? 0 : $urandom_range(0, 4);
                if (results_taken == 40 || results_taken == 400)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold != 0)
            begin
                rx_hold--;
                result_ready <= 1'b0;
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready) || (psel && penable))
                quiet_cycles = 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

endmodule
